>>> hw/rtl/sm3_message_hasher_top_defines.svh
// assertion macros for the sm3 message hasher
// used by the top level only, no other dependencies
`ifndef SM3_MESSAGE_HASHER_TOP_DEFINES_SVH
`define SM3_MESSAGE_HASHER_TOP_DEFINES_SVH
`ifndef SYNTH
`define SM3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SM3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SM3_ASSERT(lbl, prop, msg)
`define SM3_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/sm3_pkg.sv
// shared types, constants and functions of the sm3 message hasher
// no dependencies
package sm3_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_item_t;

  // one block request between front and back
  typedef struct packed {
    logic [15:0][31:0] words;
    logic              last;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h7380166F;
      3'd1: r = 32'h4914B2B9;
      3'd2: r = 32'h172442D7;
      3'd3: r = 32'hDA8A0600;
      3'd4: r = 32'hA96F30BC;
      3'd5: r = 32'h163138AA;
      3'd6: r = 32'hE38DEE4D;
      default: r = 32'hB0FB0E4E;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

endpackage

>>> hw/rtl/sm3_message_hasher_top.sv
// top level of the sm3 message hasher
// depends on sm3_pkg, sm3_front, sm3_queue, sm3_core and the defines header
`include "sm3_message_hasher_top_defines.svh"

// SM3 hasher taking one message byte per request and returning the eight
// 32-bit digest words, most significant first, after an end marker. The
// front end takes a byte every cycle while the block queue has room and no
// padding is in progress; a 64-byte block is handed on through a two-entry
// queue to the compression core, which makes one pass per round through the
// shared round unit plus a load and a chaining update per block; sustained
// input runs at about one byte per cycle. After an end marker the front end
// writes padding and length (9 to 72 bytes) one byte a cycle while the queue
// has room, and then the core shows the digest over eight output requests.
module sm3_message_hasher_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sm3_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sm3_pkg::out_item_t out_item_o
);
  import sm3_pkg::*;

  q_stat_t q_stat;
  blk_t    push_blk, pop_blk;
  logic    push, pop;

  // byte packing and padding
  sm3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_blk_o (push_blk)
  );

  // block queue
  sm3_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_blk_i (push_blk),
    .pop_i      (pop),
    .pop_blk_o  (pop_blk),
    .stat_o     (q_stat)
  );

  // compression and digest output
  sm3_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .blk_i       (pop_blk),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // checks
  `SM3_ASSERT(a_no_overflow, push |-> !q_stat.full, "block queue overflow")
  `SM3_ASSERT(a_no_underflow, pop |-> !q_stat.empty, "block queue underflow")
  `SM3_ASSERT(a_last_ends, out_valid_o && out_item_o.digest_last && !out_stall_i |=> !out_valid_o, "digest runs past last word")
  `SM3_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

>>> hw/rtl/sm3_front.sv
// front end: packs bytes into blocks, appends padding and length
// depends on sm3_pkg
module sm3_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sm3_pkg::in_item_t in_item_i,
  input  sm3_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output sm3_pkg::blk_t    push_blk_o
);
  import sm3_pkg::*;

  typedef enum logic [1:0] {
    FE_IDLE = 2'b01,
    FE_PAD  = 2'b10
  } fe_state_e;

  fe_state_e         st_q, st_d;
  logic [5:0]        pos_q, pos_d;
  logic [63:0]       count_q, count_d;
  logic              mark_q, mark_d, len_q, len_d;
  logic [15:0][31:0] buf_q, nxt_blk;
  logic              put_en, accept, last;
  logic [7:0]        put_byte;
  logic [2:0]        lane_k;

  assign in_stall_o = (st_q != FE_IDLE) || q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign lane_k     = pos_q[2:0];

  // byte source and sequencing
  always_comb begin
    st_d     = st_q;
    pos_d    = pos_q;
    count_d  = count_q;
    mark_d   = mark_q;
    len_d    = len_q;
    put_en   = 1'b0;
    put_byte = in_item_i.data_byte;
    last     = 1'b0;
    unique case (st_q)
      FE_IDLE: begin
        if (accept && in_item_i.has_byte) begin
          put_en  = 1'b1;
          count_d = count_q + 64'd8;
        end
        if (accept && in_item_i.end_of_message) begin
          st_d   = FE_PAD;
          mark_d = 1'b0;
          len_d  = 1'b0;
        end
      end
      FE_PAD: begin
        put_en = !((pos_q == 6'd63) && q_stat_i.full);
        if (!mark_q) begin
          put_byte = PadMark;
        end else if (len_q) begin
          put_byte = 8'(count_q >> {~lane_k, 3'b000});
        end else begin
          put_byte = 8'h00;
        end
        if (put_en) begin
          mark_d = 1'b1;
          if (pos_q == LenPos - 6'd1) len_d = 1'b1;
          if (len_q && (pos_q == 6'd63)) begin
            last    = 1'b1;
            st_d    = FE_IDLE;
            count_d = '0;
          end
        end
      end
      default: st_d = FE_IDLE;
    endcase
    if (put_en) pos_d = pos_q + 6'd1;
  end

  // merge the byte into its word, big-endian
  always_comb begin
    nxt_blk = buf_q;
    if (pos_q[1:0] == 2'd0) begin
      nxt_blk[pos_q[5:2]] = {put_byte, 24'h0};
    end else begin
      nxt_blk[pos_q[5:2]] = buf_q[pos_q[5:2]] |
                            (32'(put_byte) << {~pos_q[1:0], 3'b000});
    end
  end

  assign push_o           = put_en && (pos_q == 6'd63);
  assign push_blk_o.words = nxt_blk;
  assign push_blk_o.last  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= FE_IDLE;
      pos_q   <= '0;
      count_q <= '0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
    end
  end

  // block buffer
  always_ff @(posedge clk_i) begin
    if (put_en) buf_q <= nxt_blk;
  end

endmodule

>>> hw/rtl/sm3_queue.sv
// two-entry block queue between front and back
// depends on sm3_pkg
module sm3_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sm3_pkg::blk_t    push_blk_i,
  input  logic             pop_i,
  output sm3_pkg::blk_t    pop_blk_o,
  output sm3_pkg::q_stat_t stat_o
);
  import sm3_pkg::*;

  blk_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;
  assign pop_blk_o    = mem_q[rd_q];

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_blk_i;
  end

endmodule

>>> hw/rtl/sm3_core.sv
// back end: message expansion, 64 compression rounds, digest output
// depends on sm3_pkg
module sm3_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sm3_pkg::q_stat_t  q_stat_i,
  input  sm3_pkg::blk_t     blk_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sm3_pkg::out_item_t out_item_o
);
  import sm3_pkg::*;

  typedef enum logic [3:0] {
    CO_IDLE = 4'b0001,
    CO_RND  = 4'b0010,
    CO_FIN  = 4'b0100,
    CO_OUT  = 4'b1000
  } co_state_e;

  co_state_e         st_q;
  logic [7:0][31:0]  v_q;
  logic [7:0][31:0]  r_q, r_d;
  logic [15:0][31:0] w_q;
  logic [31:0]       t_q, w_new;
  logic [5:0]        rnd_q;
  logic [2:0]        idx_q;
  logic              last_q;
  logic [31:0]       a12, ss1, ss2, ffv, ggv, tt1, tt2;

  assign pop_o = (st_q == CO_IDLE) && !q_stat_i.empty;

  // one round
  always_comb begin
    a12 = rotl(r_q[0], 12);
    ss1 = rotl(a12 + r_q[4] + t_q, 7);
    ss2 = ss1 ^ a12;
    if (rnd_q < 6'd16) begin
      ffv = r_q[0] ^ r_q[1] ^ r_q[2];
      ggv = r_q[4] ^ r_q[5] ^ r_q[6];
    end else begin
      ffv = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
      ggv = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
    end
    tt1 = ffv + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = ggv + r_q[7] + ss1 + w_q[0];
    r_d = {r_q[6], rotl(r_q[5], 19), r_q[4], perm0(tt2),
           r_q[2], rotl(r_q[1], 9), r_q[0], tt1};
    w_new = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 15)) ^ rotl(w_q[3], 7) ^ w_q[10];
  end

  assign out_valid_o            = st_q == CO_OUT;
  assign out_item_o.digest_word = v_q[3'd7 - idx_q];
  assign out_item_o.digest_last = idx_q == 3'd7;

  // control and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= CO_IDLE;
      rnd_q <= '0;
      idx_q <= '0;
      for (int i = 0; i < 8; i++) v_q[7 - i] <= iv_word(3'(i));
    end else begin
      unique case (st_q)
        CO_IDLE: begin
          rnd_q <= '0;
          if (pop_o) st_q <= CO_RND;
        end
        CO_RND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) st_q <= CO_FIN;
        end
        CO_FIN: begin
          for (int i = 0; i < 8; i++) v_q[7 - i] <= v_q[7 - i] ^ r_q[i];
          idx_q <= '0;
          st_q  <= last_q ? CO_OUT : CO_IDLE;
        end
        CO_OUT: begin
          if (!out_stall_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              st_q <= CO_IDLE;
              for (int i = 0; i < 8; i++) v_q[7 - i] <= iv_word(3'(i));
            end
          end
        end
        default: st_q <= CO_IDLE;
      endcase
    end
  end

  // working registers and expansion window
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < 8; i++) r_q[i] <= v_q[7 - i];
      for (int i = 0; i < 16; i++) w_q[i] <= blk_i.words[i];
      t_q    <= TLow;
      last_q <= blk_i.last;
    end else if (st_q == CO_RND) begin
      r_q <= r_d;
      w_q <= {w_new, w_q[15:1]};
      t_q <= (rnd_q == 6'd15) ? rotl(THigh, 16) : rotl(t_q, 1);
    end
  end

endmodule

>>> tb/sm3_digest_checker.sv
// digest checker for the sm3 message hasher: watches both channels,
// computes expected digests and compares them; depends on sm3_pkg
`timescale 1ns / 1ps

module sm3_digest_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sm3_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sm3_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import sm3_pkg::*;

  localparam logic [31:0] Iv [8] = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7,
    32'hDA8A0600, 32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

  logic [31:0] chain_q [8];
  logic [31:0] blk_q [16];
  logic [63:0] bit_count_q;
  logic [5:0]  fill_q;
  out_item_t   digest_fifo [$];
  int          fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = digest_fifo.size();

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  // one sm3 compression on the current block
  task automatic compress();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, t, a12, ss1, ss2, ff, gg, tt1, tt2, x;
    for (int j = 0; j < 16; j++) w[j] = blk_q[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
      w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
    for (int j = 0; j < 64; j++) begin
      t = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(t, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e; e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
    chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
  endtask

  task automatic absorb_byte(logic [7:0] v);
    int sh;
    sh = 24 - 8 * fill_q[1:0];
    if (fill_q[1:0] == 2'd0) blk_q[fill_q[5:2]] = 32'(v) << sh;
    else blk_q[fill_q[5:2]] |= 32'(v) << sh;
    fill_q = fill_q + 6'd1;
    if (fill_q == 6'd0) compress();
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) chain_q[i] = Iv[i];
    bit_count_q = '0;
    fill_q = '0;
  endtask

  // predict digests from each accepted request
  task automatic predict_request(in_item_t it);
    logic [63:0] len;
    out_item_t   o;
    if (it.has_byte) begin
      bit_count_q += 64'd8;
      absorb_byte(it.data_byte);
    end
    if (it.end_of_message) begin
      len = bit_count_q;
      absorb_byte(PadMark);
      while (fill_q != LenPos) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(len[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain_q[i];
        o.digest_last = (i == 7);
        digest_fifo = {digest_fifo, o};
      end
      restart();
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      restart();
    end else begin
      if (in_valid_i && !in_stall_i) predict_request(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_fifo.size() == 0) begin
          $display("%0t: unexpected digest word %h last %b", $time,
                   out_item_i.digest_word, out_item_i.digest_last);
          fails++;
        end else begin
          exp_item = digest_fifo.pop_front();
          if (exp_item.digest_word !== out_item_i.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp_item.digest_word, out_item_i.digest_word);
            fails++;
          end
          if (exp_item.digest_last !== out_item_i.digest_last) begin
            $display("%0t: digest_last expected %b actual %b", $time,
                     exp_item.digest_last, out_item_i.digest_last);
            fails++;
          end
        end
      end
    end
  end

endmodule

>>> tb/testbench.sv
// stimulus and verdict for the sm3 message hasher
// depends on sm3_pkg, sm3_message_hasher_top and sm3_digest_checker
`timescale 1ns / 1ps

module testbench;
  import sm3_pkg::*;

  localparam int CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count, pending;
  int        cycles = 0;
  bit        hold_off = 1'b0;
  int        int_sizes [4] = '{55, 56, 63, 64};

  always #5 clk_i = ~clk_i;

  sm3_message_hasher_top DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item)
  );

  sm3_digest_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // one request, with a random gap in front
  task automatic send(logic [7:0] b, logic hb, logic eom);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, has_byte: hb, end_of_message: eom};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // message of random bytes with occasional byteless requests, optionally ended by a bare marker
  task automatic send_message(int n);
    bit bare;
    bare = (n == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send(8'($urandom), 1'b0, 1'b0);
      send(8'($urandom), 1'b1, !bare && (i == n - 1));
    end
    if (bare) send(8'($urandom), 1'b0, 1'b1);
  endtask

  // receiver stalls, with one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) != 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 99) < 20);
  end

  initial begin
    @(posedge clk_i);
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty message, extremes, byte plus end, padding boundaries
    send(8'h00, 1'b0, 1'b1);
    send(8'hFF, 1'b0, 1'b0);
    send(8'hFF, 1'b1, 1'b1);
    send(8'h00, 1'b1, 1'b1);
    send(8'h61, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b0);
    send(8'h63, 1'b1, 1'b1);
    send(8'hAA, 1'b1, 1'b0);
    send(8'h55, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);
    foreach (int_sizes[i]) send_message(int_sizes[i]);
    // random messages, mostly short
    for (int k = 0; k < 12; k++)
      send_message(($urandom_range(0, 9) == 0) ? $urandom_range(60, 130)
                                                : $urandom_range(0, 20));
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
